[src/assert_macros.svh]
// assertion macros shared by the rtl, sampled on clk with rst_n as reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

[src/ssmp_pkg.sv]
package ssmp_pkg;

    // configuration and sizing defaults
    localparam int WHEEL_COUNT_DEFAULT = 4;
    localparam logic [22:0] ACCEL_RESET = 23'd256;
    localparam logic [22:0] VMAX_RESET  = 23'd65536;
    localparam logic [15:0] GEAR_RESET  = 16'd256;

    // angle constants, 65536 units per turn
    localparam int QUARTER_TURN = 16384;
    localparam int HALF_TURN    = 32768;
    // half of one q8 unit, for rounding half away from zero
    localparam int ROUND_HALF   = 128;

    // action codes
    localparam logic [1:0] ACT_STEP     = 2'd0;
    localparam logic [1:0] ACT_ANGLE    = 2'd1;
    localparam logic [1:0] ACT_POSITION = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_ACCEL = 2'd0;
    localparam logic [1:0] CFG_VMAX  = 2'd1;
    localparam logic [1:0] CFG_GEAR  = 2'd2;

    // tick transaction
    typedef struct packed {
        logic [1:0]         action;
        logic [1:0]         wheel;
        logic [15:0]        target_angle;
        logic signed [15:0] wheel_speed;
        logic signed [31:0] load_value;
    } tick_item_t;

    // result transaction
    typedef struct packed {
        logic [1:0]         wheel_out;
        logic [15:0]        steer_angle;
        logic signed [31:0] motor_position;
        logic signed [15:0] drive_speed;
        logic               reversed;
    } result_item_t;

    // configuration write transaction
    typedef struct packed {
        logic [1:0]  index;
        logic [31:0] value;
    } cfg_item_t;

    // per-wheel state word held in the ram
    typedef struct packed {
        logic [15:0]        angle;
        logic signed [23:0] velocity;
        logic [31:0]        position;
        logic               reverse;
    } wheel_entry_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MULA,
        ST_MULV,
        ST_UPD,
        ST_LIM,
        ST_STEP,
        ST_MULG,
        ST_WB
    } seq_state_t;

endpackage

[src/ssmp_stream_if.sv]
// valid/ready channel carrying one payload per transaction
interface ssmp_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[src/swerve_steer_motion_profiler.sv]
// channel  | modport | payload         | role
// tick     | sink    | tick_item_t     | profile step or preset for one wheel
// result   | source  | result_item_t   | updated state and drive command
// cfg      | sink    | cfg_item_t      | register write, always ready
//
// a profile step loads the result register once the sequencer has walked the ram read,
// three multiplies (accel times error, velocity squared, step times gear ratio) and
// the write-back; a preset goes from the ram read straight to the write-back.
// one item is in flight at a time; the next is taken in the idle cycle after the ram
// write, while the previous result may still wait.
// reset clears the per-wheel valid bits, so every wheel reads as zero until written.
// a stalled result holds the sequencer in write-back until the register frees.
`include "assert_macros.svh"

module swerve_steer_motion_profiler #(
    parameter int WHEEL_COUNT = ssmp_pkg::WHEEL_COUNT_DEFAULT,
    localparam int ADDR_W = (WHEEL_COUNT > 1) ? $clog2(WHEEL_COUNT) : 1
) (
    input  logic          clk,
    input  logic          rst_n,
    ssmp_stream_if.sink   tick,
    ssmp_stream_if.source result,
    ssmp_stream_if.sink   cfg
);
    localparam int ENTRY_W = $bits(ssmp_pkg::wheel_entry_t);

    ssmp_pkg::seq_state_t state_reg, state_next;

    logic [22:0] accel_reg;
    logic [22:0] vmax_reg;
    logic [15:0] gear_reg;

    logic [WHEEL_COUNT-1:0] valid_reg;
    logic                   rd_valid_reg;

    ssmp_pkg::tick_item_t   req_reg;
    ssmp_pkg::wheel_entry_t ent_reg;
    ssmp_pkg::result_item_t res_reg;
    logic                   out_valid_reg;
    logic                   hit_reg;
    logic                   rev_reg;
    logic signed [15:0]     e_reg;
    logic [37:0]            prod_reg;
    logic [45:0]            sq_reg;
    logic signed [24:0]     v1_reg;
    logic signed [23:0]     vel_reg;
    logic [14:0]            step_mag_reg;
    logic                   step_neg_reg;
    logic [30:0]            prodg_reg;

    logic                   tick_fire;
    logic                   hit_in;
    logic                   ram_re;
    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_raddr;
    logic [ENTRY_W-1:0]     ram_rdata;
    ssmp_pkg::wheel_entry_t ram_entry;
    ssmp_pkg::wheel_entry_t wb_entry;
    ssmp_pkg::result_item_t wb_result;

    logic [15:0]        diff;
    logic signed [16:0] diff_s;
    logic signed [16:0] fold_e;
    logic               fold_rev;
    logic [14:0]        abs_e;
    logic               e_neg;
    logic [22:0]        abs_v;
    logic [47:0]        lhs;
    logic [47:0]        rhs;
    logic signed [24:0] v_ext;
    logic signed [24:0] a_ext;
    logic signed [24:0] vmax_ext;
    logic signed [24:0] v1_calc;
    logic signed [24:0] v_lim;
    logic [22:0]        abs_vel;
    logic [22:0]        abs_big_e;
    logic [22:0]        d_mag;
    logic               d_neg;
    logic [23:0]        d_round;
    logic [31:0]        mot_mag;
    logic signed [16:0] drive_neg;
    logic signed [15:0] drive_val;
    logic               vel_in_range;

    // handshakes
    assign tick.ready = (state_reg == ssmp_pkg::ST_IDLE);
    assign tick_fire  = tick.valid && tick.ready;
    assign cfg.ready  = 1'b1;
    assign result.valid = out_valid_reg;
    assign result.data  = res_reg;

    assign hit_in    = ({30'd0, tick.data.wheel} < 32'(WHEEL_COUNT));
    assign ram_re    = tick_fire && hit_in;
    assign ram_raddr = ADDR_W'(tick.data.wheel);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_reg <= ssmp_pkg::ACCEL_RESET;
            vmax_reg  <= ssmp_pkg::VMAX_RESET;
            gear_reg  <= ssmp_pkg::GEAR_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.data.index)
                ssmp_pkg::CFG_ACCEL: accel_reg <= cfg.data.value[22:0];
                ssmp_pkg::CFG_VMAX:  vmax_reg  <= cfg.data.value[22:0];
                ssmp_pkg::CFG_GEAR:  gear_reg  <= cfg.data.value[15:0];
                default:             ;
            endcase
        end
    end

    // per-wheel state memory
    ssmp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (WHEEL_COUNT)
    ) u_state_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ADDR_W'(req_reg.wheel)),
        .wdata (wb_entry),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // a wheel never written reads as zero
    assign ram_entry = rd_valid_reg ? ssmp_pkg::wheel_entry_t'(ram_rdata) : '0;

    // error wrap and quarter-turn fold
    always_comb
    begin
        diff   = req_reg.target_angle - ram_entry.angle;
        diff_s = {diff[15], diff};
        fold_rev = 1'b1;
        if (diff_s > 17'sd16384)
        begin
            fold_e = diff_s - 17'(ssmp_pkg::HALF_TURN);
        end
        else if (diff_s < -17'sd16384)
        begin
            fold_e = diff_s + 17'(ssmp_pkg::HALF_TURN);
        end
        else
        begin
            fold_e   = diff_s;
            fold_rev = 1'b0;
        end
    end

    // profile arithmetic
    always_comb
    begin
        e_neg     = e_reg[15];
        abs_e     = 15'(e_neg ? -e_reg : e_reg);
        abs_v     = 23'(ent_reg.velocity[23] ? -ent_reg.velocity : ent_reg.velocity);
        lhs       = 48'(prod_reg) << 9;
        rhs       = 48'(sq_reg) + (48'(sq_reg) << 1);
        v_ext     = 25'(ent_reg.velocity);
        a_ext     = {2'b00, accel_reg};
        vmax_ext  = {2'b00, vmax_reg};

        // accelerate, brake to zero, or brake by one step
        if (lhs > rhs)
        begin
            v1_calc = e_neg ? v_ext - a_ext : v_ext + a_ext;
        end
        else if (abs_v < accel_reg)
        begin
            v1_calc = '0;
        end
        else
        begin
            v1_calc = ent_reg.velocity[23] ? v_ext + a_ext : v_ext - a_ext;
        end

        // velocity limit
        if (v1_reg > vmax_ext)
        begin
            v_lim = vmax_ext;
        end
        else if (v1_reg < -vmax_ext)
        begin
            v_lim = -vmax_ext;
        end
        else
        begin
            v_lim = v1_reg;
        end

        // step never overshoots the error
        abs_vel   = 23'(vel_reg[23] ? -vel_reg : vel_reg);
        abs_big_e = {abs_e, 8'd0};
        if (abs_vel > abs_big_e)
        begin
            d_mag = abs_big_e;
            d_neg = e_neg;
        end
        else
        begin
            d_mag = abs_vel;
            d_neg = vel_reg[23];
        end
        d_round = 24'(d_mag) + 24'(ssmp_pkg::ROUND_HALF);

        mot_mag = (32'(prodg_reg) + 32'(ssmp_pkg::ROUND_HALF)) >> 8;

        vel_in_range = (25'(vel_reg) <= vmax_ext) && (25'(vel_reg) >= -vmax_ext);
    end

    // write-back word and result
    always_comb
    begin
        wb_entry  = ent_reg;
        drive_val = '0;
        drive_neg = -17'(req_reg.wheel_speed);
        case (req_reg.action)
            ssmp_pkg::ACT_STEP:
            begin
                wb_entry.velocity = vel_reg;
                wb_entry.reverse  = rev_reg;
                if (step_neg_reg)
                begin
                    wb_entry.angle    = ent_reg.angle - 16'(step_mag_reg);
                    wb_entry.position = ent_reg.position + mot_mag;
                end
                else
                begin
                    wb_entry.angle    = ent_reg.angle + 16'(step_mag_reg);
                    wb_entry.position = ent_reg.position - mot_mag;
                end
                if (!rev_reg)
                begin
                    drive_val = req_reg.wheel_speed;
                end
                else if (drive_neg > 17'sd32767)
                begin
                    drive_val = 16'sh7fff;
                end
                else
                begin
                    drive_val = 16'(drive_neg);
                end
            end
            ssmp_pkg::ACT_ANGLE:
            begin
                wb_entry.angle = req_reg.load_value[15:0];
            end
            ssmp_pkg::ACT_POSITION:
            begin
                wb_entry.position = req_reg.load_value;
            end
            default:
            begin
                wb_entry = ent_reg;
            end
        endcase

        wb_result.wheel_out = req_reg.wheel;
        if (hit_reg)
        begin
            wb_result.steer_angle    = wb_entry.angle;
            wb_result.motor_position = wb_entry.position;
            wb_result.drive_speed    = drive_val;
            wb_result.reversed       = wb_entry.reverse;
        end
        else
        begin
            wb_result.steer_angle    = '0;
            wb_result.motor_position = '0;
            wb_result.drive_speed    = '0;
            wb_result.reversed       = 1'b0;
        end
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        ram_we     = 1'b0;
        case (state_reg)
            ssmp_pkg::ST_IDLE:
            begin
                if (tick_fire)
                begin
                    state_next = ssmp_pkg::ST_LOAD;
                end
            end
            ssmp_pkg::ST_LOAD:
            begin
                if (hit_reg && (req_reg.action == ssmp_pkg::ACT_STEP))
                begin
                    state_next = ssmp_pkg::ST_MULA;
                end
                else
                begin
                    state_next = ssmp_pkg::ST_WB;
                end
            end
            ssmp_pkg::ST_MULA: state_next = ssmp_pkg::ST_MULV;
            ssmp_pkg::ST_MULV: state_next = ssmp_pkg::ST_UPD;
            ssmp_pkg::ST_UPD:  state_next = ssmp_pkg::ST_LIM;
            ssmp_pkg::ST_LIM:  state_next = ssmp_pkg::ST_STEP;
            ssmp_pkg::ST_STEP: state_next = ssmp_pkg::ST_MULG;
            ssmp_pkg::ST_MULG: state_next = ssmp_pkg::ST_WB;
            ssmp_pkg::ST_WB:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    ram_we     = hit_reg;
                    state_next = ssmp_pkg::ST_IDLE;
                end
            end
            default: state_next = ssmp_pkg::ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ssmp_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (ram_re)
            begin
                rd_valid_reg <= valid_reg[ram_raddr];
            end
            else if (tick_fire)
            begin
                rd_valid_reg <= 1'b0;
            end
            if (ram_we)
            begin
                valid_reg[ADDR_W'(req_reg.wheel)] <= 1'b1;
            end
            if ((state_reg == ssmp_pkg::ST_WB) && (state_next == ssmp_pkg::ST_IDLE))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ssmp_pkg::ST_IDLE:
            begin
                if (tick_fire)
                begin
                    req_reg <= tick.data;
                    hit_reg <= hit_in;
                end
            end
            ssmp_pkg::ST_LOAD:
            begin
                ent_reg <= ram_entry;
                e_reg   <= 16'(fold_e);
                rev_reg <= fold_rev;
            end
            ssmp_pkg::ST_MULA: prod_reg <= 38'(abs_e) * 38'(accel_reg);
            ssmp_pkg::ST_MULV: sq_reg   <= 46'(abs_v) * 46'(abs_v);
            ssmp_pkg::ST_UPD:  v1_reg   <= v1_calc;
            ssmp_pkg::ST_LIM:  vel_reg  <= 24'(v_lim);
            ssmp_pkg::ST_STEP:
            begin
                step_mag_reg <= 15'(d_round >> 8);
                step_neg_reg <= d_neg;
            end
            ssmp_pkg::ST_MULG: prodg_reg <= 31'(step_mag_reg) * 31'(gear_reg);
            ssmp_pkg::ST_WB:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    res_reg <= wb_result;
                end
            end
            default: ;
        endcase
    end

    // checks on the sequencer and datapath
    `ASSERT_NEXT(a_accept_loads, tick_fire, state_reg == ssmp_pkg::ST_LOAD,
        "accept not followed by load")
    `ASSERT_IMPLY(a_result_from_wb, $rose(out_valid_reg),
        $past(state_reg) == ssmp_pkg::ST_WB, "result without write-back")
    `ASSERT_IMPLY(a_vel_clamped, state_reg == ssmp_pkg::ST_STEP, vel_in_range,
        "velocity outside limit")
    `ASSERT_IMPLY(a_step_bounded, state_reg == ssmp_pkg::ST_MULG,
        step_mag_reg <= 15'd16384, "step beyond quarter turn")
    `ASSERT_IMPLY(a_write_only_wb, ram_we, (state_reg == ssmp_pkg::ST_WB) && hit_reg,
        "ram write outside write-back")
endmodule

[src/ssmp_ram.sv]
// single-port-write, single-port-read ram with registered read data
module ssmp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

[dv/swerve_steer_motion_profiler_tb.sv]
module swerve_steer_motion_profiler_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // action 3 has no meaning in the block, it only reports the wheel state
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int WHEELS = ssmp_pkg::WHEEL_COUNT_DEFAULT;
    localparam int PHASES = 8;
    localparam int PHASE_TICKS = 118;
    localparam int LONG_HOLD = 300;
    localparam int SETTLE_CYCLES = 16;

    // one row of the directed part: tick, whether the result is typed in, and that result
    typedef struct packed {
        ssmp_pkg::tick_item_t   item;
        logic                   typed;
        ssmp_pkg::result_item_t want;
    } tick_row_t;

    logic clk;
    logic rst_n;

    ssmp_stream_if #(.payload_t(ssmp_pkg::tick_item_t))   tick_if ();
    ssmp_stream_if #(.payload_t(ssmp_pkg::result_item_t)) res_if ();
    ssmp_stream_if #(.payload_t(ssmp_pkg::cfg_item_t))    cfg_if ();

    swerve_steer_motion_profiler u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (tick_if),
        .result (res_if),
        .cfg    (cfg_if)
    );

    // predictor copy of the registers and the per-wheel state
    logic [22:0] accel_cfg = ssmp_pkg::ACCEL_RESET;
    logic [22:0] vmax_cfg  = ssmp_pkg::VMAX_RESET;
    logic [15:0] gear_cfg  = ssmp_pkg::GEAR_RESET;
    logic [15:0] wheel_angle [WHEELS] = '{default: '0};
    longint      wheel_vel   [WHEELS] = '{default: 0};
    logic [31:0] wheel_pos   [WHEELS] = '{default: '0};
    logic        wheel_rev   [WHEELS] = '{default: 1'b0};
    logic [15:0] wheel_goal  [WHEELS] = '{default: '0};

    ssmp_pkg::result_item_t pending_q [$];
    int unsigned  failures = 0;
    int unsigned  ticks_sent = 0;
    int unsigned  results_taken = 0;
    bit           hold_req = 1'b0;

    // directed stimulus, default registers, starting from reset
    tick_row_t directed_rows [23] = '{
        '{'{ACT_UNUSED,             2'd0, 16'h0000, 16'h0000, 32'h0000_0000}, 1'b1,
          '{2'd0, 16'h0000, 32'h0000_0000, 16'h0000, 1'b0}},
        '{'{ssmp_pkg::ACT_ANGLE,    2'd1, 16'h0000, 16'h7FFF, 32'h7FFF_FFFF}, 1'b1,
          '{2'd1, 16'hFFFF, 32'h0000_0000, 16'h0000, 1'b0}},
        '{'{ssmp_pkg::ACT_POSITION, 2'd1, 16'hFFFF, 16'h8000, 32'h8000_0000}, 1'b1,
          '{2'd1, 16'hFFFF, 32'h8000_0000, 16'h0000, 1'b0}},
        '{'{ssmp_pkg::ACT_POSITION, 2'd2, 16'h1234, 16'h0001, 32'h7FFF_FFFF}, 1'b1,
          '{2'd2, 16'h0000, 32'h7FFF_FFFF, 16'h0000, 1'b0}},
        '{'{ssmp_pkg::ACT_ANGLE,    2'd3, 16'hFFFF, 16'hFFFF, 32'hFFFF_0000}, 1'b1,
          '{2'd3, 16'h0000, 32'h0000_0000, 16'h0000, 1'b0}},
        '{'{ssmp_pkg::ACT_STEP,     2'd0, 16'h0000, 16'h8000, 32'hFFFF_FFFF}, 1'b1,
          '{2'd0, 16'h0000, 32'h0000_0000, 16'h8000, 1'b0}},
        // half-turn error folds to zero with reversal, drive saturates
        '{'{ssmp_pkg::ACT_STEP,     2'd0, 16'h8000, 16'h8000, 32'h0000_0000}, 1'b1,
          '{2'd0, 16'h0000, 32'h0000_0000, 16'h7FFF, 1'b1}},
        '{'{ssmp_pkg::ACT_STEP,     2'd0, 16'h4000, 16'h7FFF, 32'h5A5A_A5A5}, 1'b0, '0},
        '{'{ssmp_pkg::ACT_STEP,     2'd0, 16'h4001, 16'h0001, 32'h0000_0000}, 1'b0, '0},
        '{'{ssmp_pkg::ACT_STEP,     2'd0, 16'h4003, 16'h0064, 32'h0000_0000}, 1'b0, '0},
        '{'{ssmp_pkg::ACT_STEP,     2'd1, 16'h0000, 16'h7FFF, 32'h0000_0000}, 1'b0, '0},
        '{'{ssmp_pkg::ACT_STEP,     2'd2, 16'hFFFF, 16'hFFFF, 32'h0000_0000}, 1'b0, '0},
        '{'{ssmp_pkg::ACT_STEP,     2'd3, 16'hC000, 16'h0000, 32'h0000_0000}, 1'b0, '0},
        '{'{ssmp_pkg::ACT_STEP,     2'd3, 16'hC000, 16'h0000, 32'h0000_0000}, 1'b0, '0},
        '{'{ssmp_pkg::ACT_STEP,     2'd3, 16'hC000, 16'h0000, 32'h0000_0000}, 1'b0, '0},
        '{'{ssmp_pkg::ACT_STEP,     2'd3, 16'hC000, 16'h0000, 32'h0000_0000}, 1'b0, '0},
        '{'{ssmp_pkg::ACT_STEP,     2'd3, 16'hC000, 16'h0000, 32'h0000_0000}, 1'b0, '0},
        '{'{ssmp_pkg::ACT_STEP,     2'd3, 16'h4000, 16'h8001, 32'h0000_0000}, 1'b0, '0},
        '{'{ACT_UNUSED,             2'd3, 16'h1111, 16'h2222, 32'h3333_4444}, 1'b0, '0},
        '{'{ssmp_pkg::ACT_STEP,     2'd2, 16'h7FFF, 16'h8000, 32'h0000_0000}, 1'b0, '0},
        '{'{ssmp_pkg::ACT_STEP,     2'd1, 16'h8001, 16'h1234, 32'hA5A5_5A5A}, 1'b0, '0},
        '{'{ssmp_pkg::ACT_STEP,     2'd2, 16'h8000, 16'h0000, 32'h0000_0000}, 1'b0, '0},
        '{'{ssmp_pkg::ACT_POSITION, 2'd3, 16'h0000, 16'h0000, 32'h0000_0000}, 1'b0, '0}
    };

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic longint mag(input longint x);
        return (x < 0) ? -x : x;
    endfunction

    // q8 to whole units, half away from zero
    function automatic longint round_units(input longint x);
        longint m;
        m = (mag(x) + ssmp_pkg::ROUND_HALF) / 256;
        return (x < 0) ? -m : m;
    endfunction

    // profile step or preset on the predictor state, returns the expected result
    function automatic ssmp_pkg::result_item_t predict_tick(input ssmp_pkg::tick_item_t it);
        ssmp_pkg::result_item_t r;
        logic [15:0]  diff;
        longint       e;
        longint       err;
        longint       a;
        longint       vmax;
        longint       v;
        longint       d;
        longint       stp;
        longint       mot;
        longint       drv;
        int           w;
        w = int'(it.wheel);
        drv = 0;
        case (it.action)
            ssmp_pkg::ACT_STEP:
            begin
                diff = it.target_angle - wheel_angle[w];
                e = longint'($signed(diff));
                // beyond a quarter turn steer to the opposite angle and reverse
                if (e > ssmp_pkg::QUARTER_TURN || e < -ssmp_pkg::QUARTER_TURN)
                begin
                    e = (e > 0) ? e - ssmp_pkg::HALF_TURN : e + ssmp_pkg::HALF_TURN;
                    wheel_rev[w] = 1'b1;
                end
                else
                begin
                    wheel_rev[w] = 1'b0;
                end
                err = e * 256;
                a = longint'(accel_cfg);
                vmax = longint'(vmax_cfg);
                v = wheel_vel[w];
                // accelerate while the error exceeds the stop distance, else brake
                if (2 * a * mag(err) > 3 * v * v)
                    v = v + ((err >= 0) ? a : -a);
                else if (mag(v) < a)
                    v = 0;
                else
                    v = v - ((v >= 0) ? a : -a);
                if (v > vmax)
                    v = vmax;
                if (v < -vmax)
                    v = -vmax;
                wheel_vel[w] = v;
                // never step past the error
                d = v;
                if (mag(d) > mag(err))
                    d = err;
                stp = round_units(d);
                wheel_angle[w] = wheel_angle[w] + stp[15:0];
                mot = round_units(stp * longint'(gear_cfg));
                wheel_pos[w] = wheel_pos[w] - mot[31:0];
                drv = wheel_rev[w] ? -longint'(it.wheel_speed) : longint'(it.wheel_speed);
                if (drv > 32767)
                    drv = 32767;
            end
            ssmp_pkg::ACT_ANGLE:
                wheel_angle[w] = it.load_value[15:0];
            ssmp_pkg::ACT_POSITION:
                wheel_pos[w] = it.load_value;
            default:
                ;
        endcase
        r.wheel_out = it.wheel;
        r.steer_angle = wheel_angle[w];
        r.motor_position = wheel_pos[w];
        r.drive_speed = drv[15:0];
        r.reversed = wheel_rev[w];
        return r;
    endfunction

    // random tick, mostly profile steps chasing a per-wheel goal
    function automatic ssmp_pkg::tick_item_t next_random_tick();
        ssmp_pkg::tick_item_t it;
        int unsigned pick;
        int unsigned aim;
        it.wheel = 2'($urandom_range(0, WHEELS - 1));
        it.wheel_speed = 16'($urandom);
        it.load_value = $urandom;
        it.target_angle = 16'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 5)
            wheel_goal[it.wheel] = 16'($urandom);
        if (pick < 78)
            it.action = ssmp_pkg::ACT_STEP;
        else if (pick < 86)
            it.action = ssmp_pkg::ACT_ANGLE;
        else if (pick < 93)
            it.action = ssmp_pkg::ACT_POSITION;
        else
            it.action = ACT_UNUSED;
        aim = $urandom_range(0, 9);
        if (aim < 7)
            it.target_angle = wheel_goal[it.wheel];
        else if (aim == 7)
            it.target_angle = wheel_goal[it.wheel] + 16'($urandom_range(0, 64)) - 16'd32;
        else if (aim == 8)
            it.target_angle = wheel_goal[it.wheel] ^ 16'h8000;
        return it;
    endfunction

    // idle cycles before the next transaction, with stretches of none
    function automatic int unsigned idle_cycles(input int unsigned count);
        return ((count % 64) >= 48) ? 0 : $urandom_range(0, 14);
    endfunction

    function automatic void note_failure(input string msg);
        failures++;
        if (failures <= 10)
            $display("%s", msg);
    endfunction

    // offer one tick and record its expected result once taken
    task automatic offer_tick(input ssmp_pkg::tick_item_t it, input logic typed,
                              input ssmp_pkg::result_item_t typed_want);
        int unsigned  gap;
        ssmp_pkg::result_item_t want;
        gap = idle_cycles(ticks_sent);
        if (gap > 0)
        begin
            tick_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tick_if.valid <= 1'b1;
        tick_if.data <= it;
        @(posedge clk);
        while (!tick_if.ready)
            @(posedge clk);
        want = predict_tick(it);
        if (typed)
            want = typed_want;
        pending_q.push_back(want);
        ticks_sent++;
    endtask

    // drop valid and let every outstanding result drain
    task automatic close_phase();
        tick_if.valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.data <= '{idx, val};
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        case (idx)
            ssmp_pkg::CFG_ACCEL: accel_cfg = val[22:0];
            ssmp_pkg::CFG_VMAX:  vmax_cfg  = val[22:0];
            ssmp_pkg::CFG_GEAR:  gear_cfg  = val[15:0];
            default:   ;
        endcase
        cfg_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    // main stimulus
    initial
    begin : stimulus
        logic [22:0] a_set;
        logic [22:0] v_set;
        logic [15:0] g_set;
        rst_n <= 1'b0;
        tick_if.valid <= 1'b0;
        tick_if.data <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.data <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            offer_tick(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
        close_phase();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:
                begin
                    a_set = 23'd1;       v_set = 23'h7F_FFFF; g_set = 16'hFFFF;
                end
                1:
                begin
                    a_set = 23'h7F_FFFF; v_set = 23'h7F_FFFF; g_set = 16'h0000;
                end
                2:
                begin
                    a_set = 23'h7F_FFFF; v_set = 23'd0;       g_set = 16'hFFFF;
                end
                3:
                begin
                    a_set = ssmp_pkg::ACCEL_RESET;
                    v_set = ssmp_pkg::VMAX_RESET;
                    g_set = ssmp_pkg::GEAR_RESET;
                end
                default:
                begin
                    a_set = ($urandom_range(0, 1) == 0) ? 23'($urandom_range(1, 1024))
                                                        : 23'($urandom_range(1, 23'h7F_FFFF));
                    v_set = ($urandom_range(0, 1) == 0) ? 23'($urandom_range(0, 65536))
                                                        : 23'($urandom);
                    g_set = 16'($urandom);
                end
            endcase
            // upper bits beyond each register width carry noise
            write_reg(ssmp_pkg::CFG_ACCEL, ($urandom & 32'hFF80_0000) | 32'(a_set));
            write_reg(ssmp_pkg::CFG_VMAX, ($urandom & 32'hFF80_0000) | 32'(v_set));
            write_reg(ssmp_pkg::CFG_GEAR, ($urandom & 32'hFFFF_0000) | 32'(g_set));
            if (p == 3)
                hold_req = 1'b1;
            for (int i = 0; i < PHASE_TICKS; i++)
                offer_tick(next_random_tick(), 1'b0, '0);
            close_phase();
        end

        if (failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // result side back-pressure, with one long hold on request
    initial
    begin : result_drain
        int unsigned n;
        int unsigned held;
        res_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                res_if.ready <= 1'b0;
                held = 0;
                while (held < LONG_HOLD)
                begin
                    @(posedge clk);
                    held++;
                end
                hold_req = 1'b0;
            end
            n = idle_cycles(results_taken + 20);
            if (n > 0)
            begin
                res_if.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            res_if.ready <= 1'b1;
            @(posedge clk);
            while (!(res_if.valid && res_if.ready))
                @(posedge clk);
            results_taken++;
        end
    end

    // compare each result transaction with the oldest expectation
    always @(posedge clk)
    begin : result_check
        ssmp_pkg::result_item_t want;
        ssmp_pkg::result_item_t got;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            got = res_if.data;
            if (pending_q.size() == 0)
            begin
                note_failure($sformatf(
                    {"unexpected result: wheel %0d angle %h pos %h drive %0d",
                     " rev %b"},
                    got.wheel_out, got.steer_angle, got.motor_position, got.drive_speed,
                    got.reversed));
            end
            else
            begin
                want = pending_q.pop_front();
                if (got.wheel_out !== want.wheel_out || got.steer_angle !== want.steer_angle
                    || got.motor_position !== want.motor_position
                    || got.drive_speed !== want.drive_speed || got.reversed !== want.reversed)
                begin
                    note_failure($sformatf(
                        {"mismatch: exp wheel %0d angle %h pos %h drive %0d rev %b",
                         " | got wheel %0d angle %h pos %h drive %0d rev %b"},
                        want.wheel_out, want.steer_angle, want.motor_position, want.drive_speed,
                        want.reversed, got.wheel_out, got.steer_angle, got.motor_position,
                        got.drive_speed, got.reversed));
                end
            end
        end
    end

    // watchdog
    initial
    begin : watchdog
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
